>>> hw/rtl/wpsm_pkg.sv
// shared types, constants and register codes of the wheel pulse speed meter
`timescale 1ns / 1ps
package wpsm_pkg;

    localparam int unsigned ADC_BITS    = 10;
    localparam int unsigned TIME_BITS   = 32;
    localparam int unsigned THR_BITS    = 10;
    localparam int unsigned MS_BITS     = 16;
    localparam int unsigned CIRC_BITS   = 12;
    localparam int unsigned PERIOD_BITS = 16;
    localparam int unsigned SPEED_BITS  = 10;
    localparam int unsigned CMP_BITS    = (ADC_BITS > THR_BITS) ? ADC_BITS : THR_BITS;

    localparam int unsigned SPEED_FACTOR  = 36;
    localparam int unsigned SPEED_MAX     = 999;
    localparam int unsigned DIVIDEND_BITS =
        $clog2(SPEED_FACTOR * ((2 ** CIRC_BITS) - 1) + 1);
    localparam int unsigned STEP_BITS     = $clog2(DIVIDEND_BITS);

    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned PTR_BITS   = $clog2(FIFO_DEPTH);
    localparam int unsigned CNT_BITS   = $clog2(FIFO_DEPTH + 1);

    localparam int unsigned CFG_IDX_BITS  = 3;
    localparam int unsigned CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] REG_LEVEL_THRESHOLD  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_MIN_GAP_MS       = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_TIMEOUT_MS       = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_CIRCUMFERENCE_MM = 3'd3;

    localparam logic [THR_BITS-1:0]  RST_LEVEL_THRESHOLD  = 10'd512;
    localparam logic [MS_BITS-1:0]   RST_MIN_GAP_MS       = 16'd50;
    localparam logic [MS_BITS-1:0]   RST_TIMEOUT_MS       = 16'd3000;
    localparam logic [CIRC_BITS-1:0] RST_CIRCUMFERENCE_MM = 12'd2000;

    typedef struct packed {
        logic [THR_BITS-1:0]  level_threshold;
        logic [MS_BITS-1:0]   min_gap_ms;
        logic [MS_BITS-1:0]   timeout_ms;
        logic [CIRC_BITS-1:0] circumference_mm;
    } t_cfg;

    typedef struct packed {
        logic                   speed_valid;
        logic [PERIOD_BITS-1:0] period_ms;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

endpackage

>>> hw/rtl/wpsm_in_if.sv
// input channel: timestamp and adc sample
`timescale 1ns / 1ps
interface wpsm_in_if;
    logic                         valid;
    logic                         ready;
    logic [wpsm_pkg::TIME_BITS-1:0] time_ms;
    logic [wpsm_pkg::ADC_BITS-1:0]  sample;

    modport source (output valid, output time_ms, output sample, input ready);
    modport sink (input valid, input time_ms, input sample, output ready);
endinterface

>>> hw/rtl/wpsm_out_if.sv
// output channel: valid flag, period and speed
`timescale 1ns / 1ps
interface wpsm_out_if;
    logic                            valid;
    logic                            ready;
    logic                            speed_valid;
    logic [wpsm_pkg::PERIOD_BITS-1:0] period_ms;
    logic [wpsm_pkg::SPEED_BITS-1:0]  speed_tenths_kmh;

    modport source (output valid, output speed_valid, output period_ms,
                    output speed_tenths_kmh, input ready);
    modport sink (input valid, input speed_valid, input period_ms,
                  input speed_tenths_kmh, output ready);
endinterface

>>> hw/rtl/wpsm_front.sv
// front end: threshold, edge detect, debounce, period capture and timeout
`timescale 1ns / 1ps
module wpsm_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  wpsm_pkg::t_cfg        i_cfg,
    input  logic                  i_full,
    wpsm_in_if.sink               i_in,
    output logic                  o_push,
    output wpsm_pkg::t_entry      o_entry
);

    logic                               r_prev_level;
    logic                               r_seen;
    logic [wpsm_pkg::TIME_BITS-1:0]     r_last;
    logic [wpsm_pkg::PERIOD_BITS-1:0]   r_period;
    logic                               r_valid;

    logic                               n_seen;
    logic [wpsm_pkg::TIME_BITS-1:0]     n_last;
    logic [wpsm_pkg::PERIOD_BITS-1:0]   n_period;
    logic                               n_valid;

    logic                               accept;
    logic                               level;
    logic                               fall;
    logic                               upd;
    logic [wpsm_pkg::TIME_BITS-1:0]     gap;
    logic [wpsm_pkg::TIME_BITS-1:0]     gap_now;
    logic [wpsm_pkg::TIME_BITS-1:0]     min_gap;
    logic [wpsm_pkg::TIME_BITS-1:0]     timeout;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;

    assign level   = wpsm_pkg::CMP_BITS'(i_in.sample)
                     >= wpsm_pkg::CMP_BITS'(i_cfg.level_threshold);
    assign fall    = r_prev_level && !level;
    assign gap     = i_in.time_ms - r_last;
    assign min_gap = wpsm_pkg::TIME_BITS'(i_cfg.min_gap_ms);
    assign timeout = wpsm_pkg::TIME_BITS'(i_cfg.timeout_ms);

    always_comb begin
        n_seen   = r_seen;
        n_last   = r_last;
        n_period = r_period;
        n_valid  = r_valid;
        upd      = 1'b0;
        if (fall) begin
            if (!r_seen) begin
                n_seen = 1'b1;
                n_last = i_in.time_ms;
                upd    = 1'b1;
            end else if (gap >= min_gap) begin
                if (gap < timeout) begin
                    n_period = wpsm_pkg::PERIOD_BITS'(gap);
                    n_valid  = 1'b1;
                end
                n_last = i_in.time_ms;
                upd    = 1'b1;
            end
        end
        gap_now = upd ? '0 : gap;
        // wheel stopped
        if (n_seen && gap_now >= timeout) begin
            n_period = '0;
            n_valid  = 1'b1;
        end
    end

    assign o_push              = accept;
    assign o_entry.speed_valid = n_valid;
    assign o_entry.period_ms   = n_period;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_level <= 1'b1;
            r_seen       <= 1'b0;
            r_last       <= '0;
            r_period     <= '0;
            r_valid      <= 1'b0;
        end else if (accept) begin
            r_prev_level <= level;
            r_seen       <= n_seen;
            r_last       <= n_last;
            r_period     <= n_period;
            r_valid      <= n_valid;
        end
    end

endmodule

>>> hw/rtl/wpsm_fifo.sv
// short queue between front end and speed unit
`timescale 1ns / 1ps
module wpsm_fifo (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  wpsm_pkg::t_entry        i_entry,
    input  logic                    i_pop,
    output wpsm_pkg::t_entry        o_entry,
    output wpsm_pkg::t_fifo_stat    o_stat
);

    wpsm_pkg::t_entry                 r_mem [wpsm_pkg::FIFO_DEPTH];
    logic [wpsm_pkg::PTR_BITS-1:0]    r_wr_ptr;
    logic [wpsm_pkg::PTR_BITS-1:0]    r_rd_ptr;
    logic [wpsm_pkg::CNT_BITS-1:0]    r_count;

    logic do_push;
    logic do_pop;

    assign o_stat.full  = (r_count == wpsm_pkg::CNT_BITS'(wpsm_pkg::FIFO_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_entry      = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> hw/rtl/wpsm_back.sv
// speed unit: bit-serial divide of 36 x circumference by period, output register
`timescale 1ns / 1ps
module wpsm_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  wpsm_pkg::t_cfg          i_cfg,
    input  wpsm_pkg::t_fifo_stat    i_stat,
    input  wpsm_pkg::t_entry        i_entry,
    output logic                    o_pop,
    wpsm_out_if.source              o_out
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_DONE
    } t_state;

    t_state                                  r_state;
    logic                                    r_valid;
    logic [wpsm_pkg::PERIOD_BITS-1:0]        r_period;
    logic [wpsm_pkg::DIVIDEND_BITS-1:0]      r_dividend;
    logic [wpsm_pkg::PERIOD_BITS-1:0]        r_rem;
    logic [wpsm_pkg::DIVIDEND_BITS-1:0]      r_quot;
    logic [wpsm_pkg::STEP_BITS-1:0]          r_step;

    logic                                    r_out_valid;
    logic                                    r_out_speed_valid;
    logic [wpsm_pkg::PERIOD_BITS-1:0]        r_out_period;
    logic [wpsm_pkg::SPEED_BITS-1:0]         r_out_speed;

    logic [wpsm_pkg::DIVIDEND_BITS-1:0]      dividend;
    logic [wpsm_pkg::PERIOD_BITS:0]          rem_sh;
    logic                                    ge;
    logic [wpsm_pkg::PERIOD_BITS-1:0]        rem_next;
    logic [wpsm_pkg::SPEED_BITS-1:0]         speed;
    logic                                    out_free;

    // 36 x c = 32 x c + 4 x c
    assign dividend = (wpsm_pkg::DIVIDEND_BITS'(i_cfg.circumference_mm) << 5)
                    + (wpsm_pkg::DIVIDEND_BITS'(i_cfg.circumference_mm) << 2);

    assign rem_sh   = {r_rem, r_dividend[wpsm_pkg::DIVIDEND_BITS-1]};
    assign ge       = rem_sh >= {1'b0, r_period};
    assign rem_next = ge ? wpsm_pkg::PERIOD_BITS'(rem_sh - {1'b0, r_period})
                         : wpsm_pkg::PERIOD_BITS'(rem_sh);

    assign speed    = (r_quot > wpsm_pkg::DIVIDEND_BITS'(wpsm_pkg::SPEED_MAX))
                    ? '0 : wpsm_pkg::SPEED_BITS'(r_quot);
    assign out_free = !r_out_valid || o_out.ready;
    assign o_pop    = (r_state == S_IDLE) && !i_stat.empty;

    assign o_out.valid            = r_out_valid;
    assign o_out.speed_valid      = r_out_speed_valid;
    assign o_out.period_ms        = r_out_period;
    assign o_out.speed_tenths_kmh = r_out_speed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_out.ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_stat.empty) begin
                        r_valid    <= i_entry.speed_valid;
                        r_period   <= i_entry.period_ms;
                        r_dividend <= dividend;
                        r_rem      <= '0;
                        r_quot     <= '0;
                        r_step     <= wpsm_pkg::STEP_BITS'(wpsm_pkg::DIVIDEND_BITS - 1);
                        // no division when invalid or stopped
                        if (!i_entry.speed_valid || i_entry.period_ms == '0) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    r_rem      <= rem_next;
                    r_quot     <= {r_quot[wpsm_pkg::DIVIDEND_BITS-2:0], ge};
                    r_dividend <= r_dividend << 1;
                    r_step     <= r_step - 1'b1;
                    if (r_step == '0) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid       <= 1'b1;
                        r_out_speed_valid <= r_valid;
                        r_out_period      <= r_period;
                        r_out_speed       <= speed;
                        r_state           <= S_IDLE;
                    end else begin
                        r_out_valid       <= r_out_valid;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> hw/rtl/wheel_pulse_speed_meter.sv
// top level of the wheel pulse speed meter
//
// items on i_in carry a millisecond timestamp and one adc sample of the
// wheel sensor; every accepted item gives exactly one item on o_out with
// the valid flag, the last period in ms and the speed in 0.1 km/h.
// both channels use valid/ready; an item moves when both are high.
// registers are written through i_cfg_we / i_cfg_idx / i_cfg_data; the
// user is to write them only while the block is idle (the block itself
// does not enforce this); unknown indexes are ignored. the front end
// takes one item per cycle, while the queue is not full, into a
// four-entry queue; the speed unit divides 36 x circumference by the
// period one quotient bit per cycle (18 steps) and takes the next queued
// item only once its result is in the output register; invalid or
// stopped items skip the divide. when o_out stalls, the result waits in
// the output register while the speed unit and queue keep filling;
// i_in.ready drops when the queue is full. reset restores the register
// defaults, a high line, no pulse seen and an empty queue.
`timescale 1ns / 1ps
module wheel_pulse_speed_meter (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [wpsm_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [wpsm_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    wpsm_in_if.sink                              i_in,
    wpsm_out_if.source                           o_out
);

    wpsm_pkg::t_cfg        r_cfg;
    wpsm_pkg::t_entry      push_entry;
    wpsm_pkg::t_entry      pop_entry;
    wpsm_pkg::t_fifo_stat  fifo_stat;
    logic                  push;
    logic                  pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.level_threshold  <= wpsm_pkg::RST_LEVEL_THRESHOLD;
            r_cfg.min_gap_ms       <= wpsm_pkg::RST_MIN_GAP_MS;
            r_cfg.timeout_ms       <= wpsm_pkg::RST_TIMEOUT_MS;
            r_cfg.circumference_mm <= wpsm_pkg::RST_CIRCUMFERENCE_MM;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                wpsm_pkg::REG_LEVEL_THRESHOLD: begin
                    r_cfg.level_threshold <= wpsm_pkg::THR_BITS'(i_cfg_data);
                end
                wpsm_pkg::REG_MIN_GAP_MS: begin
                    r_cfg.min_gap_ms <= wpsm_pkg::MS_BITS'(i_cfg_data);
                end
                wpsm_pkg::REG_TIMEOUT_MS: begin
                    r_cfg.timeout_ms <= wpsm_pkg::MS_BITS'(i_cfg_data);
                end
                wpsm_pkg::REG_CIRCUMFERENCE_MM: begin
                    r_cfg.circumference_mm <= wpsm_pkg::CIRC_BITS'(i_cfg_data);
                end
                default: begin
                end
            endcase
        end
    end

    wpsm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_full  (fifo_stat.full),
        .i_in    (i_in),
        .o_push  (push),
        .o_entry (push_entry)
    );

    wpsm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_entry (pop_entry),
        .o_stat  (fifo_stat)
    );

    wpsm_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_stat  (fifo_stat),
        .i_entry (pop_entry),
        .o_pop   (pop),
        .o_out   (o_out)
    );

    a_fifo_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(fifo_stat.full && fifo_stat.empty))
        else $error("queue full and empty at once");

    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> !fifo_stat.empty)
        else $error("accepted item missing from queue");

    a_speed_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.speed_tenths_kmh <= wpsm_pkg::SPEED_BITS'(wpsm_pkg::SPEED_MAX))
        else $error("speed above limit");

    a_speed_needs_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.speed_tenths_kmh != '0)
            |-> (o_out.speed_valid && o_out.period_ms != '0))
        else $error("speed without valid period");

endmodule
